[rtl/tmf_pkg.sv]
package tmf_pkg;

  localparam int DATA_W = 12;
  localparam int CH_W   = 3;

  localparam logic [DATA_W-1:0] DATA_MAX = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] DATA_MIN = '0;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STREAM,
    ST_FLUSH,
    ST_DRAIN,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

[rtl/tmf_cell.sv]
module tmf_cell #(
  parameter bit MIN_SIDE = 1'b1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tmf_pkg::cell_ctl_t          ctl,
  input  logic                        in_valid,
  input  logic [tmf_pkg::DATA_W-1:0]  in_data,
  input  logic [tmf_pkg::DATA_W-1:0]  shift_data,
  output logic [tmf_pkg::DATA_W-1:0]  held,
  output logic                        pass_valid,
  output logic [tmf_pkg::DATA_W-1:0]  pass_data
);

  logic [tmf_pkg::DATA_W-1:0] held_r, pass_r;
  logic                       pass_valid_r;
  logic                       take_in;

  // min side keeps the smaller value and hands the larger one on
  assign take_in = MIN_SIDE ? (in_data < held_r) : (in_data > held_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_valid_r <= 1'b0;
      held_r       <= MIN_SIDE ? tmf_pkg::DATA_MAX : tmf_pkg::DATA_MIN;
    end else if (ctl.clear) begin
      pass_valid_r <= 1'b0;
      held_r       <= MIN_SIDE ? tmf_pkg::DATA_MAX : tmf_pkg::DATA_MIN;
    end else if (ctl.shift) begin
      pass_valid_r <= 1'b0;
      held_r       <= shift_data;
    end else if (in_valid) begin
      pass_valid_r <= 1'b1;
      held_r       <= take_in ? in_data : held_r;
      pass_r       <= take_in ? held_r : in_data;
    end else begin
      pass_valid_r <= 1'b0;
    end
  end

  assign held       = held_r;
  assign pass_valid = pass_valid_r;
  assign pass_data  = pass_r;

endmodule

[rtl/trimmed_mean_adc_filter_top.sv]
// channel  ports                                          handshake
// input    in_req_type, in_channel, in_sample             start && !busy
// result   out_mean_value, out_result_channel             out_valid, one cycle
//
// a sample write leaves busy low; a compute request keeps busy high while SAMPLES words are read
// into two chains of cells, the chains settle, the chains drain and one reciprocal multiply runs;
// the result is registered from that multiply and strobes as busy falls.
// a request for a missing channel, or with nothing left after trimming, answers next cycle.
// after reset a clearing pass writes zero to all SAMPLES*CHANNELS words, busy is high meanwhile.
// the receiver cannot stall; out_valid is a one-cycle strobe.
module trimmed_mean_adc_filter_top #(
  parameter int SAMPLES  = 100,
  parameter int CHANNELS = 8,
  parameter int TRIM     = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [tmf_pkg::CH_W-1:0]    in_channel,
  input  logic [tmf_pkg::DATA_W-1:0]  in_sample,
  output logic                        out_valid,
  output logic [tmf_pkg::DATA_W-1:0]  out_mean_value,
  output logic [tmf_pkg::CH_W-1:0]    out_result_channel
);

  localparam int DW     = tmf_pkg::DATA_W;
  localparam int WORDS  = SAMPLES * CHANNELS;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NC     = (TRIM > 0) ? TRIM : 1;
  localparam bit EMPTY  = (2 * TRIM >= SAMPLES);
  localparam int KEEP   = EMPTY ? 1 : SAMPLES - 2 * TRIM;
  localparam int SW     = $clog2(SAMPLES * 4096 + 1);
  localparam int LOGK   = $clog2(KEEP);
  localparam int SHIFT  = SW + LOGK;
  localparam int MW     = SW + 1;
  localparam int PW     = SW + MW;
  // floor(n / KEEP) == (n * RECIP) >> SHIFT for every n below 2**SW
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + 64'(KEEP) - 64'd1) / 64'(KEEP);
  localparam logic [MW-1:0] RECIP_K = MW'(RECIP);
  localparam int CNT_W  = $clog2(WORDS + SAMPLES + TRIM + 16);

  logic [DW-1:0] mem [WORDS];

  tmf_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    wpos_r, wpos_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [DW-1:0]    rd_data_r;
  logic             rd_valid_r;
  logic [tmf_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic [SW-1:0]    total_r, total_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SW-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]    prod;
  logic             out_valid_r, out_valid_nxt;
  logic [DW-1:0]    mean_r, mean_nxt;
  logic [tmf_pkg::CH_W-1:0] och_r, och_nxt;

  logic             we;
  logic [AW-1:0]    wa;
  logic [DW-1:0]    wd;

  tmf_pkg::cell_ctl_t ctl;

  logic [DW-1:0] lo_held [NC];
  logic [DW-1:0] hi_held [NC];
  logic          lo_pv   [NC];
  logic          hi_pv   [NC];
  logic [DW-1:0] lo_pd   [NC];
  logic [DW-1:0] hi_pd   [NC];

  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_cells
      tmf_cell #(.MIN_SIDE(1'b1)) u_lo (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .in_valid   ((g == 0) ? rd_valid_r : lo_pv[(g == 0) ? 0 : g - 1]),
        .in_data    ((g == 0) ? rd_data_r  : lo_pd[(g == 0) ? 0 : g - 1]),
        .shift_data ((g == 0) ? tmf_pkg::DATA_MAX : lo_held[(g == 0) ? 0 : g - 1]),
        .held       (lo_held[g]),
        .pass_valid (lo_pv[g]),
        .pass_data  (lo_pd[g])
      );
      tmf_cell #(.MIN_SIDE(1'b0)) u_hi (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .in_valid   ((g == 0) ? rd_valid_r : hi_pv[(g == 0) ? 0 : g - 1]),
        .in_data    ((g == 0) ? rd_data_r  : hi_pd[(g == 0) ? 0 : g - 1]),
        .shift_data ((g == 0) ? tmf_pkg::DATA_MIN : hi_held[(g == 0) ? 0 : g - 1]),
        .held       (hi_held[g]),
        .pass_valid (hi_pv[g]),
        .pass_data  (hi_pd[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmf_pkg::ST_CLEAR;
      cnt_r       <= '0;
      wpos_r      <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wpos_r      <= wpos_nxt;
      rd_valid_r  <= (state_r == tmf_pkg::ST_STREAM);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    ch_r      <= ch_nxt;
    total_r   <= total_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    rem_r     <= rem_nxt;
    mean_r    <= mean_nxt;
    och_r     <= och_nxt;
  end

  assign prod = PW'(rem_r) * PW'(RECIP_K);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    wpos_nxt      = wpos_r;
    rd_addr_nxt   = rd_addr_r;
    ch_nxt        = ch_r;
    total_nxt     = total_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    rem_nxt       = rem_r;
    mean_nxt      = mean_r;
    och_nxt       = och_r;
    out_valid_nxt = 1'b0;
    we            = 1'b0;
    wa            = wpos_r;
    wd            = in_sample;
    ctl.clear     = 1'b0;
    ctl.shift     = 1'b0;

    if (rd_valid_r) begin
      total_nxt = total_r + SW'(rd_data_r);
    end

    case (state_r)
      tmf_pkg::ST_CLEAR: begin
        we = 1'b1;
        wa = cnt_r[AW-1:0];
        wd = '0;
        if (cnt_r == CNT_W'(WORDS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tmf_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tmf_pkg::ST_IDLE: begin
        if (start) begin
          if (in_req_type == tmf_pkg::REQ_WRITE) begin
            we = 1'b1;
            wpos_nxt = (wpos_r == AW'(WORDS - 1)) ? '0 : wpos_r + 1'b1;
          end else if (EMPTY || (32'(in_channel) >= 32'(CHANNELS))) begin
            out_valid_nxt = 1'b1;
            mean_nxt      = '0;
            och_nxt       = in_channel;
          end else begin
            ctl.clear   = 1'b1;
            ch_nxt      = in_channel;
            rd_addr_nxt = AW'(in_channel);
            total_nxt   = '0;
            lo_nxt      = '0;
            hi_nxt      = '0;
            cnt_nxt     = '0;
            state_nxt   = tmf_pkg::ST_STREAM;
          end
        end
      end
      tmf_pkg::ST_STREAM: begin
        rd_addr_nxt = rd_addr_r + AW'(CHANNELS);
        if (cnt_r == CNT_W'(SAMPLES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tmf_pkg::ST_FLUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tmf_pkg::ST_FLUSH: begin
        // last sample still walking down the chains
        if (cnt_r == CNT_W'(NC + 2)) begin
          cnt_nxt   = '0;
          state_nxt = tmf_pkg::ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tmf_pkg::ST_DRAIN: begin
        ctl.shift = 1'b1;
        lo_nxt = lo_r + SW'(lo_held[NC-1]);
        hi_nxt = hi_r + SW'(hi_held[NC-1]);
        if (cnt_r == CNT_W'(NC - 1)) begin
          cnt_nxt   = '0;
          rem_nxt   = (TRIM > 0) ? (total_r - lo_nxt - hi_nxt) : total_r;
          state_nxt = tmf_pkg::ST_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      tmf_pkg::ST_DIV: begin
        out_valid_nxt = 1'b1;
        mean_nxt      = prod[SHIFT +: DW];
        och_nxt       = ch_r;
        state_nxt     = tmf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tmf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != tmf_pkg::ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_mean_value     = mean_r;
  assign out_result_channel = och_r;

endmodule

[tb/sv/trimmed_mean_adc_filter_top_test.sv]
`timescale 1ns / 1ps

module trimmed_mean_adc_filter_top_test;

  localparam int SAMPLES  = 100;
  localparam int CHANNELS = 8;
  localparam int TRIM     = 10;
  localparam int WORDS    = SAMPLES * CHANNELS;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_ITEMS  = 200;

  typedef struct {
    logic                       req;
    logic [tmf_pkg::CH_W-1:0]   ch;
    logic [tmf_pkg::DATA_W-1:0] smp;
    int                         gap;
    bit                         hold;
  } adc_item_t;

  typedef struct {
    logic [tmf_pkg::DATA_W-1:0] mean;
    logic [tmf_pkg::CH_W-1:0]   ch;
  } mean_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_req_type = tmf_pkg::REQ_WRITE;
  logic [tmf_pkg::CH_W-1:0]   in_channel = '0;
  logic [tmf_pkg::DATA_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic [tmf_pkg::DATA_W-1:0] out_mean_value;
  logic [tmf_pkg::CH_W-1:0]   out_result_channel;

  adc_item_t   pending_items[$];
  mean_t       expected_means[$];
  logic [tmf_pkg::DATA_W-1:0] adc_store[WORDS];
  int          wr_pos = 0;
  int          gap_cnt = 0;
  int          errors = 0;
  int          stall_cycles = 0;
  int          total_items = 0;

  trimmed_mean_adc_filter_top #(
    .SAMPLES(SAMPLES), .CHANNELS(CHANNELS), .TRIM(TRIM)
  ) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_channel(in_channel), .in_sample(in_sample),
    .out_valid(out_valid), .out_mean_value(out_mean_value),
    .out_result_channel(out_result_channel)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [tmf_pkg::DATA_W-1:0] trimmed_avg(input int ch);
    logic [tmf_pkg::DATA_W-1:0] buf_v[SAMPLES];
    logic [tmf_pkg::DATA_W-1:0] v;
    int k;
    int unsigned sum;
    int keep;
    sum = 0;
    if (ch >= CHANNELS || 2 * TRIM >= SAMPLES) return '0;
    keep = SAMPLES - 2 * TRIM;
    for (int i = 0; i < SAMPLES; i++) buf_v[i] = adc_store[i * CHANNELS + ch];
    for (int i = 1; i < SAMPLES; i++) begin
      v = buf_v[i];
      k = i;
      while (k > 0 && buf_v[k-1] > v) begin
        buf_v[k] = buf_v[k-1];
        k--;
      end
      buf_v[k] = v;
    end
    for (int i = TRIM; i < TRIM + keep; i++) sum += buf_v[i];
    return tmf_pkg::DATA_W'(sum / keep);
  endfunction

  function automatic void add_item(logic req, int ch, int smp, bit hold);
    adc_item_t it;
    it.req  = req;
    it.ch   = tmf_pkg::CH_W'(ch);
    it.smp  = tmf_pkg::DATA_W'(smp);
    it.hold = hold;
    it.gap  = 0;
    // idle bursts, none near the end
    if (total_items < 1850 - TAIL_ITEMS && $urandom_range(0, 3) == 0)
      it.gap = $urandom_range(1, 7);
    pending_items.push_back(it);
    total_items++;
  endfunction

  // driver
  always @(posedge clk) begin
    adc_item_t it;
    mean_t m;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        stall_cycles = 0;
        if (in_req_type == tmf_pkg::REQ_WRITE) begin
          adc_store[wr_pos] = in_sample;
          wr_pos = (wr_pos + 1) % WORDS;
        end else begin
          m.mean = trimmed_avg(in_channel);
          m.ch   = in_channel;
          expected_means.push_back(m);
        end
      end
      if (start && busy) begin
        // hold the item until accepted
      end else if (gap_cnt > 0) begin
        gap_cnt--;
        start <= 1'b0;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].hold && expected_means.size() > 0)) begin
        it = pending_items.pop_front();
        in_req_type <= it.req;
        in_channel  <= it.ch;
        in_sample   <= it.smp;
        start       <= 1'b1;
        gap_cnt = it.gap;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mean_t m;
    if (rst_n && out_valid) begin
      stall_cycles = 0;
      if (expected_means.size() == 0) begin
        $error("unexpected result: mean_value %0d result_channel %0d",
               out_mean_value, out_result_channel);
        errors++;
      end else begin
        m = expected_means.pop_front();
        if (out_mean_value !== m.mean) begin
          $error("mean_value: expected %0d actual %0d", m.mean, out_mean_value);
          errors++;
        end
        if (out_result_channel !== m.ch) begin
          $error("result_channel: expected %0d actual %0d", m.ch, out_result_channel);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[trimmed_mean_adc_filter_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int mode;
    int base;
    for (int i = 0; i < WORDS; i++) adc_store[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extremes, ignored fields
    add_item(tmf_pkg::REQ_COMPUTE, 0, 4095, 1'b0);
    add_item(tmf_pkg::REQ_COMPUTE, 7, 0, 1'b0);
    add_item(tmf_pkg::REQ_WRITE, 7, 4095, 1'b0);
    add_item(tmf_pkg::REQ_WRITE, 0, 0, 1'b0);
    add_item(tmf_pkg::REQ_WRITE, 5, 4095, 1'b0);
    add_item(tmf_pkg::REQ_WRITE, 2, 1, 1'b0);
    add_item(tmf_pkg::REQ_WRITE, 1, 2048, 1'b0);
    add_item(tmf_pkg::REQ_WRITE, 6, 2047, 1'b0);
    add_item(tmf_pkg::REQ_WRITE, 3, 4094, 1'b0);
    add_item(tmf_pkg::REQ_WRITE, 4, 4095, 1'b0);
    for (int c = 0; c < CHANNELS; c++) add_item(tmf_pkg::REQ_COMPUTE, c, 4095 - c, 1'b0);
    add_item(tmf_pkg::REQ_COMPUTE, 3, 0, 1'b1);

    // random: whole scans with varied content, rare requests
    while (total_items < 1850) begin
      mode = $urandom_range(0, 9);
      base = $urandom_range(0, 4095);
      if ($urandom_range(0, 19) == 0) begin
        // noise: a lone write that shifts the scan alignment
        add_item(tmf_pkg::REQ_WRITE, $urandom_range(0, 7), $urandom_range(0, 4095), 1'b0);
      end else begin
        for (int c = 0; c < CHANNELS; c++) begin
          case (mode)
            0: add_item(tmf_pkg::REQ_WRITE, $urandom_range(0, 7), 4095, 1'b0);
            1: add_item(tmf_pkg::REQ_WRITE, $urandom_range(0, 7), 0, 1'b0);
            // ties: values bunched around one level
            2, 3: add_item(tmf_pkg::REQ_WRITE, $urandom_range(0, 7),
                           (base & 12'hff8) + $urandom_range(0, 3), 1'b0);
            default: add_item(tmf_pkg::REQ_WRITE, $urandom_range(0, 7),
                              $urandom_range(0, 4095), 1'b0);
          endcase
        end
      end
      if ($urandom_range(0, 3) == 0)
        add_item(tmf_pkg::REQ_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 4095),
                 $urandom_range(0, 15) == 0);
    end
    add_item(tmf_pkg::REQ_COMPUTE, $urandom_range(0, 7), 0, 1'b0);

    wait (pending_items.size() == 0);
    @(posedge clk);
    while (start) @(posedge clk);
    wait (expected_means.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_means.size() == 0) begin
      $display("[trimmed_mean_adc_filter_top] OK");
    end else begin
      $display("[trimmed_mean_adc_filter_top] ERROR");
    end
    $finish;
  end

endmodule
